// ----- rtl/core/motion_setpoint_limiter_core_macros.svh -----
// ----------------------------------------------------------------------------
// motion_setpoint_limiter_core_macros
// Assertion helpers for the checker file msl_chk.
// ----------------------------------------------------------------------------
`ifndef MOTION_SETPOINT_LIMITER_CORE_MACROS_SVH
`define MOTION_SETPOINT_LIMITER_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define MSL_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define MSL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/msl_pkg.sv -----
// ----------------------------------------------------------------------------
// msl_pkg
// Types and constants of the motion setpoint limiter.
// ----------------------------------------------------------------------------
package msl_pkg;

  typedef enum logic [2:0] {
    REG_FLOOR   = 3'd0,
    REG_CEILING = 3'd1,
    REG_SPEED   = 3'd2,
    REG_ACCEL   = 3'd3,
    REG_MARGIN  = 3'd4,
    REG_NOBRAKE = 3'd5,
    REG_SCALE   = 3'd6
  } cfg_idx_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_PREP,
    OP_MUL_UU,
    OP_DIV_START,
    OP_SOFT,
    OP_STEP,
    OP_MUL_AP,
    OP_MUL_X,
    OP_DECIDE,
    OP_HARD,
    OP_MUL_DRV,
    OP_OUT
  } op_t;

  typedef struct packed {
    logic accept;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic axis_ok;
    logic div_done;
  } sts_t;

  localparam logic signed [31:0] FLOOR_RST   = -32'sd16777216;
  localparam logic signed [31:0] CEILING_RST = 32'sd16777216;
  localparam logic [30:0]        SPEED_RST   = 31'd16777;
  localparam logic [30:0]        ACCEL_RST   = 31'd168;
  localparam logic [30:0]        MARGIN_RST  = 31'd16777;
  localparam logic [31:0]        NOBRAKE_RST = 32'd1000000;
  localparam logic [31:0]        SCALE_RST   = 32'd65536;

  localparam logic [63:0] STOP_SAT = 64'h0000_0100_0000_0000;

endpackage

// ----- rtl/core/msl_ifs.sv -----
// ----------------------------------------------------------------------------
// msl interfaces
// Request, command and register-write channels, valid/ready.
// ----------------------------------------------------------------------------
interface msl_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        axis;
  logic signed [31:0] requested_position;
  modport source (output valid, axis, requested_position, input ready);
  modport sink   (input valid, axis, requested_position, output ready);
endinterface

interface msl_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         axis_out;
  logic signed [31:0] commanded_position;
  logic [31:0]        drive_increments;
  logic               braking;
  logic               hard_clamped;
  logic               limits_conflict;
  modport source (output valid, axis_out, commanded_position, drive_increments,
                  braking, hard_clamped, limits_conflict, input ready);
  modport sink   (input valid, axis_out, commanded_position, drive_increments,
                  braking, hard_clamped, limits_conflict, output ready);
endinterface

interface msl_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/motion_setpoint_limiter_core.sv -----
// ----------------------------------------------------------------------------
// motion_setpoint_limiter_core
// Per-axis position setpoint limiter with soft, step, braking and hard limits.
// ----------------------------------------------------------------------------
// A request on an axis outside the range skips from PREP straight to OUT.
// One request in flight: the next is taken only in IDLE, once the last has
// left OUT. The 64-step bit-serial stop-distance divider is the slowest step.
// A finished word waits in the output register while the next request runs.
// Synchronous reset clears the axis history and loads register defaults.
module motion_setpoint_limiter_core #(
  parameter int NUM_AXES = 3
) (
  input  logic      clk,
  input  logic      rst_n,
  msl_in_if.sink    in_if,
  msl_out_if.source out_if,
  msl_cfg_if.sink   cfg_if
);

  msl_pkg::cmd_t cmd;
  msl_pkg::sts_t sts;

  assign cfg_if.ready = 1'b1;

  msl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  msl_dp #(.NUM_AXES(NUM_AXES)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_axis    (in_if.axis),
    .in_pos     (in_if.requested_position),
    .cfg_we     (cfg_if.valid),
    .cfg_index  (cfg_if.index),
    .cfg_data   (cfg_if.data),
    .o_axis     (out_if.axis_out),
    .o_pos      (out_if.commanded_position),
    .o_drive    (out_if.drive_increments),
    .o_brake    (out_if.braking),
    .o_hard     (out_if.hard_clamped),
    .o_conflict (out_if.limits_conflict)
  );

endmodule

// ----- rtl/core/msl_div.sv -----
// ----------------------------------------------------------------------------
// msl_div
// Restoring divider, 64-bit dividend by 31-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module msl_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [30:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);

  logic [63:0] sh_r;
  logic [30:0] rem_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [31:0] trial;
  logic        ge;
  logic [31:0] rem_nxt;

  assign trial   = {rem_r, sh_r[63]};
  assign ge      = trial >= {1'b0, divisor};
  assign rem_nxt = ge ? (trial - {1'b0, divisor}) : trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == 6'd63);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) busy_r <= 1'b0;
      end
    end
  end

  // quotient bits shift in where dividend bits leave
  always_ff @(posedge clk) begin
    if (start) begin
      sh_r  <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      sh_r  <= {sh_r[62:0], ge};
      rem_r <= rem_nxt[30:0];
    end
  end

  assign done     = done_r;
  assign quotient = sh_r;

endmodule

// ----- rtl/core/msl_dp.sv -----
// ----------------------------------------------------------------------------
// msl_dp
// Datapath: registers, axis history, shared multiplier, divider, limits.
// ----------------------------------------------------------------------------
module msl_dp #(
  parameter int NUM_AXES = 3
) (
  input  logic               clk,
  input  logic               rst_n,
  input  msl_pkg::cmd_t      cmd,
  output msl_pkg::sts_t      sts,
  input  logic [1:0]         in_axis,
  input  logic signed [31:0] in_pos,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic [1:0]         o_axis,
  output logic signed [31:0] o_pos,
  output logic [31:0]        o_drive,
  output logic               o_brake,
  output logic               o_hard,
  output logic               o_conflict
);

  localparam int AW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

  // configuration
  logic signed [31:0] floor_r, ceil_r;
  logic [30:0]        speed_r, accel_r, margin_r;
  logic [31:0]        nobrake_r, scale_r;

  // axis history
  logic signed [31:0] lcmd_r [NUM_AXES];
  logic signed [31:0] pcmd_r [NUM_AXES];
  logic signed [31:0] lreq_r [NUM_AXES];
  logic signed [31:0] preq_r [NUM_AXES];

  // working registers
  logic [1:0]         axis_r;
  logic signed [31:0] want_r, c0_r, r_r, fin_r;
  logic signed [32:0] d_r, rd_r;
  logic [63:0]        uu_r;
  logic [67:0]        prod_r;
  logic [65:0]        ap_r;
  logic signed [34:0] lo_r, hi_r, wu_r;
  logic signed [35:0] lim_r;
  logic [33:0]        w_r;
  logic [32:0]        pm_r;
  logic               ppos_r, cond_r, brake_r, hard_r, conflict_r, bad_r;

  logic [4:0]     axis_ext;
  logic [AW-1:0]  idx;
  logic           dneg;
  logic signed [32:0] nd;
  logic [31:0]    u;
  logic [30:0]    acc;
  logic [33:0]    mul_a, mul_b;
  logic [67:0]    prod_nxt;
  logic           div_done;
  logic [63:0]    quo;

  assign axis_ext = {3'b000, axis_r};
  assign idx      = axis_ext[AW-1:0];
  assign dneg     = d_r[32];
  assign nd       = -d_r;
  assign u        = dneg ? nd[31:0] : d_r[31:0];
  assign acc      = (accel_r == '0) ? 31'd1 : accel_r;

  assign sts.axis_ok  = axis_ext < 5'(NUM_AXES);
  assign sts.div_done = div_done;

  msl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.op == msl_pkg::OP_DIV_START),
    .dividend (prod_r[63:0]),
    .divisor  (acc),
    .done     (div_done),
    .quotient (quo)
  );

  // ---- soft limits and step window
  logic [40:0]        qs;
  logic signed [42:0] tpos, term;
  logic signed [43:0] shi, slo, want44, rs, marg44;
  logic signed [31:0] rsat;
  logic signed [34:0] acc35, spd35, dma, dpa, lo_c, hi_c;
  logic               conflict_c;

  assign qs     = (quo > msl_pkg::STOP_SAT) ? msl_pkg::STOP_SAT[40:0] : quo[40:0];
  assign tpos   = signed'({2'b00, qs});
  assign term   = dneg ? -tpos : tpos;
  assign marg44 = signed'({13'd0, margin_r});
  assign shi    = 44'(ceil_r) - 44'(term) - marg44;
  assign slo    = 44'(floor_r) - 44'(term) + marg44;
  assign want44 = 44'(want_r);

  always_comb begin
    if (want44 < slo)      rs = slo;
    else if (want44 > shi) rs = shi;
    else                   rs = want44;
    if (rs < -44'sd2147483648)     rsat = 32'sh8000_0000;
    else if (rs > 44'sd2147483647) rsat = 32'sh7fff_ffff;
    else                           rsat = rs[31:0];
  end

  assign acc35      = signed'({4'd0, acc});
  assign spd35      = signed'({4'd0, speed_r});
  assign dma        = 35'(d_r) - acc35;
  assign dpa        = 35'(d_r) + acc35;
  assign lo_c       = (dma < -spd35) ? -spd35 : dma;
  assign hi_c       = (dpa > spd35) ? spd35 : dpa;
  assign conflict_c = lo_c > hi_c;

  // ---- step clamp and braking operands
  logic signed [33:0] diff, vd;
  logic signed [34:0] diff35, p35;
  logic signed [35:0] c036, lim_c;
  logic [33:0]        w_c;

  assign diff   = 34'(r_r) - 34'(c0_r);
  assign diff35 = 35'(diff);
  assign c036   = 36'(c0_r);
  assign p35    = dneg ? -diff35 : diff35;
  assign vd     = 34'(rd_r) - 34'(d_r);
  assign w_c    = vd[33] ? 34'(-vd) : 34'(vd);

  always_comb begin
    if (diff35 < lo_r)      lim_c = c036 + 36'(lo_r);
    else if (diff35 > hi_r) lim_c = c036 + 36'(hi_r);
    else                    lim_c = 36'(r_r);
  end

  // ---- braking decision
  logic        cond_c;
  logic [33:0] absd;
  logic [69:0] x70, ap70, uu70;
  logic        brake_c;
  logic signed [34:0] bd;
  logic signed [35:0] blim;

  assign cond_c = ppos_r ? ({2'b00, uu_r} > prod_r[65:0])
                         : ((uu_r != '0) || (prod_r[65:0] != '0));
  assign absd   = wu_r[34] ? 34'(-wu_r) : 34'(wu_r);
  assign x70    = {2'b00, prod_r};
  assign ap70   = {4'd0, ap_r};
  assign uu70   = {6'd0, uu_r};

  always_comb begin
    if (cond_r) begin
      if (ppos_r) brake_c = !wu_r[34] || (uu70 > x70 + ap70);
      else        brake_c = (!wu_r[34] && wu_r != '0) && (x70 > uu70 + ap70);
    end else begin
      brake_c = (nobrake_r != '0) && ({36'd0, w_r} > x70);
    end
  end

  assign bd = dneg ? (35'(d_r) + acc35) : (35'(d_r) - acc35);

  always_comb begin
    if (bd < lo_r)      blim = c036 + 36'(lo_r);
    else if (bd > hi_r) blim = c036 + 36'(hi_r);
    else                blim = c036 + 36'(bd);
  end

  // ---- hard clamp and drive scaling
  logic signed [31:0] fin_c;
  logic               hard_c;
  logic signed [32:0] fin33;
  logic [31:0]        finm;
  logic [31:0]        drv_mag, drive_c;

  always_comb begin
    if (lim_r < 36'(floor_r)) begin
      fin_c  = floor_r;
      hard_c = 1'b1;
    end else if (lim_r > 36'(ceil_r)) begin
      fin_c  = ceil_r;
      hard_c = 1'b1;
    end else begin
      fin_c  = lim_r[31:0];
      hard_c = 1'b0;
    end
  end

  assign fin33   = -33'(fin_r);
  assign finm    = fin_r[31] ? fin33[31:0] : fin_r;
  assign drv_mag = {8'd0, prod_r[63:40]};
  assign drive_c = fin_r[31] ? (32'd0 - drv_mag) : drv_mag;

  // ---- shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      msl_pkg::OP_MUL_UU: begin
        mul_a = {2'b00, u};
        mul_b = {2'b00, u};
      end
      msl_pkg::OP_MUL_AP: begin
        mul_a = {2'b00, acc, 1'b0};
        mul_b = {1'b0, pm_r};
      end
      msl_pkg::OP_MUL_X: begin
        mul_a = cond_c ? absd : {2'b00, nobrake_r};
        mul_b = cond_c ? absd : {3'b000, acc};
      end
      msl_pkg::OP_MUL_DRV: begin
        mul_a = {2'b00, finm};
        mul_b = {2'b00, scale_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = mul_a * mul_b;

  // ---- configuration and history; reset loads defaults and clears history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_r   <= msl_pkg::FLOOR_RST;
      ceil_r    <= msl_pkg::CEILING_RST;
      speed_r   <= msl_pkg::SPEED_RST;
      accel_r   <= msl_pkg::ACCEL_RST;
      margin_r  <= msl_pkg::MARGIN_RST;
      nobrake_r <= msl_pkg::NOBRAKE_RST;
      scale_r   <= msl_pkg::SCALE_RST;
      for (int i = 0; i < NUM_AXES; i++) begin
        lcmd_r[i] <= '0;
        pcmd_r[i] <= '0;
        lreq_r[i] <= '0;
        preq_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (msl_pkg::cfg_idx_t'(cfg_index))
          msl_pkg::REG_FLOOR:   floor_r   <= cfg_data;
          msl_pkg::REG_CEILING: ceil_r    <= cfg_data;
          msl_pkg::REG_SPEED:   speed_r   <= cfg_data[30:0];
          msl_pkg::REG_ACCEL:   accel_r   <= cfg_data[30:0];
          msl_pkg::REG_MARGIN:  margin_r  <= cfg_data[30:0];
          msl_pkg::REG_NOBRAKE: nobrake_r <= cfg_data;
          msl_pkg::REG_SCALE:   scale_r   <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.op == msl_pkg::OP_HARD) begin
        preq_r[idx] <= lreq_r[idx];
        lreq_r[idx] <= r_r;
        pcmd_r[idx] <= lcmd_r[idx];
        lcmd_r[idx] <= fin_c;
      end
    end
  end

  // ---- working registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      axis_r <= in_axis;
      want_r <= in_pos;
    end
    unique case (cmd.op)
      msl_pkg::OP_PREP: begin
        bad_r <= !sts.axis_ok;
        c0_r  <= lcmd_r[idx];
        d_r   <= 33'(lcmd_r[idx]) - 33'(pcmd_r[idx]);
        rd_r  <= 33'(lreq_r[idx]) - 33'(preq_r[idx]);
      end
      msl_pkg::OP_MUL_UU: prod_r <= prod_nxt;
      msl_pkg::OP_DIV_START: uu_r <= prod_r[63:0];
      msl_pkg::OP_SOFT: begin
        r_r        <= rsat;
        conflict_r <= conflict_c;
        lo_r       <= conflict_c ? '0 : lo_c;
        hi_r       <= conflict_c ? '0 : hi_c;
      end
      msl_pkg::OP_STEP: begin
        lim_r  <= lim_c;
        pm_r   <= p35[34] ? 33'(-p35) : 33'(p35);
        ppos_r <= !p35[34] && (p35 != '0);
        w_r    <= w_c;
        wu_r   <= signed'({1'b0, w_c}) - signed'({3'b000, u});
      end
      msl_pkg::OP_MUL_AP: prod_r <= prod_nxt;
      msl_pkg::OP_MUL_X: begin
        ap_r   <= prod_r[65:0];
        cond_r <= cond_c;
        prod_r <= prod_nxt;
      end
      msl_pkg::OP_DECIDE: begin
        brake_r <= brake_c;
        if (brake_c) lim_r <= blim;
      end
      msl_pkg::OP_HARD: begin
        fin_r  <= fin_c;
        hard_r <= hard_c;
      end
      msl_pkg::OP_MUL_DRV: prod_r <= prod_nxt;
      msl_pkg::OP_OUT: begin
        o_axis     <= axis_r;
        o_pos      <= bad_r ? '0 : fin_r;
        o_drive    <= bad_r ? '0 : drive_c;
        o_brake    <= !bad_r && brake_r;
        o_hard     <= !bad_r && hard_r;
        o_conflict <= !bad_r && conflict_r;
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/core/msl_ctrl.sv -----
// ----------------------------------------------------------------------------
// msl_ctrl
// Sequencer for one request at a time, plus the result word's valid flag.
// ----------------------------------------------------------------------------
module msl_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  msl_pkg::sts_t sts,
  output msl_pkg::cmd_t cmd
);

  typedef enum logic [12:0] {
    S_IDLE    = 13'b0000000000001,
    S_PREP    = 13'b0000000000010,
    S_MUL_UU  = 13'b0000000000100,
    S_DIV_ST  = 13'b0000000001000,
    S_DIV     = 13'b0000000010000,
    S_SOFT    = 13'b0000000100000,
    S_STEP    = 13'b0000001000000,
    S_MUL_AP  = 13'b0000010000000,
    S_MUL_X   = 13'b0000100000000,
    S_DECIDE  = 13'b0001000000000,
    S_HARD    = 13'b0010000000000,
    S_MUL_DRV = 13'b0100000000000,
    S_OUT     = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);
  assign cmd.accept = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = msl_pkg::OP_NONE;
    unique case (state_r)
      S_IDLE:    if (in_valid) state_nxt = S_PREP;
      S_PREP: begin
        cmd.op    = msl_pkg::OP_PREP;
        state_nxt = sts.axis_ok ? S_MUL_UU : S_OUT;
      end
      S_MUL_UU: begin
        cmd.op    = msl_pkg::OP_MUL_UU;
        state_nxt = S_DIV_ST;
      end
      S_DIV_ST: begin
        cmd.op    = msl_pkg::OP_DIV_START;
        state_nxt = S_DIV;
      end
      S_DIV:     if (sts.div_done) state_nxt = S_SOFT;
      S_SOFT: begin
        cmd.op    = msl_pkg::OP_SOFT;
        state_nxt = S_STEP;
      end
      S_STEP: begin
        cmd.op    = msl_pkg::OP_STEP;
        state_nxt = S_MUL_AP;
      end
      S_MUL_AP: begin
        cmd.op    = msl_pkg::OP_MUL_AP;
        state_nxt = S_MUL_X;
      end
      S_MUL_X: begin
        cmd.op    = msl_pkg::OP_MUL_X;
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.op    = msl_pkg::OP_DECIDE;
        state_nxt = S_HARD;
      end
      S_HARD: begin
        cmd.op    = msl_pkg::OP_HARD;
        state_nxt = S_MUL_DRV;
      end
      S_MUL_DRV: begin
        cmd.op    = msl_pkg::OP_MUL_DRV;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // hold until the result register can take the word
        if (out_free) begin
          cmd.op    = msl_pkg::OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.op == msl_pkg::OP_OUT) out_valid_nxt = 1'b1;
    else if (out_ready)            out_valid_nxt = 1'b0;
    else                           out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- rtl/core/msl_chk.sv -----
// ----------------------------------------------------------------------------
// msl_chk
// Port-level checks on the limiter, bound to the top level.
// ----------------------------------------------------------------------------
`include "motion_setpoint_limiter_core_macros.svh"

module msl_chk #(
  parameter int NUM_AXES = 3
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  axis_out,
  input logic [31:0] commanded_position,
  input logic [31:0] drive_increments,
  input logic        braking,
  input logic        hard_clamped,
  input logic        limits_conflict
);

  `MSL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(commanded_position) && $stable(drive_increments),
    "result word changed while stalled")

  `MSL_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready,
    "second request taken while one is in work")

  `MSL_ASSERT_SAME(a_bad_axis_zero, out_valid && ({3'b000, axis_out} >= 5'(NUM_AXES)),
    commanded_position == '0 && drive_increments == '0 && !braking &&
    !hard_clamped && !limits_conflict,
    "nonzero result for an axis out of range")

endmodule

bind motion_setpoint_limiter_core msl_chk #(.NUM_AXES(NUM_AXES)) u_msl_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_if.valid),
  .in_ready           (in_if.ready),
  .out_valid          (out_if.valid),
  .out_ready          (out_if.ready),
  .axis_out           (out_if.axis_out),
  .commanded_position (out_if.commanded_position),
  .drive_increments   (out_if.drive_increments),
  .braking            (out_if.braking),
  .hard_clamped       (out_if.hard_clamped),
  .limits_conflict    (out_if.limits_conflict)
);
